// ----- rtl/core/pptc_pkg.sv -----
// Shared types and constants for the port pair traffic counters.
// Used by pptc_front, pptc_back and the top level; depends on nothing.
package pptc_pkg;

  localparam int PORT_W = 3;
  localparam int MASK_W = 8;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 2;
  localparam int PKT_W  = 48;
  localparam int BYTE_W = 56;
  localparam int N_W    = 3;
  localparam int INC_W  = 19;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic ACTION_COUNT = 1'b0;
  localparam logic ACTION_DUMP  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

  typedef struct packed {
    logic              dump;
    logic              src_ok;
    logic [PORT_W-1:0] src;
    logic [MASK_W-1:0] dests;
    logic [N_W-1:0]    n;
    logic [LEN_W-1:0]  len;
    logic [INC_W-1:0]  byte_inc;
  } cmd_t;

endpackage

// ----- rtl/core/port_pair_traffic_counters_unit.sv -----
// Port pair traffic counters: top level with the configuration port.
// Depends on pptc_pkg, pptc_front and pptc_back.
//
// Input words arrive on item_valid/item_ready. A count word adds one packet
// and packet_length bytes to each active destination pair of its source row
// and to the grand totals, and returns one acknowledgement word with last set.
// A dump word returns PORTS*(PORTS-1) pair words in row-major order and then
// a totals word with last set, after which every counter reads zero.
// Results leave on record_valid/record_ready from an output register.
// In the back end a count word first reads the source row of the counter
// memory and then updates and writes it back, loading the acknowledgement
// into the output register with the write; the next command is taken only
// after that write. A dump does one row read and PORTS lane steps per source,
// then loads the totals word. A two-entry command queue lets the input keep
// accepting while the receiver stalls; when the output register is held, the
// back end waits and the queue fills. Reset clears all counters at once
// through per-row valid bits and sets active_ports to all ones.
module port_pair_traffic_counters_unit #(
  parameter int PORTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        action,
  input  logic [pptc_pkg::PORT_W-1:0] source_port,
  input  logic [pptc_pkg::MASK_W-1:0] destination_mask,
  input  logic [pptc_pkg::LEN_W-1:0]  packet_length,
  output logic                        record_valid,
  input  logic                        record_ready,
  output logic [pptc_pkg::KIND_W-1:0] record_kind,
  output logic [pptc_pkg::PORT_W-1:0] from_port,
  output logic [pptc_pkg::PORT_W-1:0] to_port,
  output logic [pptc_pkg::PKT_W-1:0]  packet_total,
  output logic [pptc_pkg::BYTE_W-1:0] byte_total,
  output logic                        last
);
  import pptc_pkg::*;

  localparam logic REG_ACTIVE_PORTS = 1'b0;

  logic [MASK_W-1:0] active_ports;
  logic              cfg_write;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_PORTS);
  assign prdata    = (paddr[2] == REG_ACTIVE_PORTS) ? {24'b0, active_ports} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ports <= '1;
    end else if (cfg_write) begin
      active_ports <= pwdata[MASK_W-1:0];
    end
  end

  pptc_front #(
    .PORTS(PORTS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .active_ports    (active_ports),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .action          (action),
    .source_port     (source_port),
    .destination_mask(destination_mask),
    .packet_length   (packet_length),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  pptc_back #(
    .PORTS(PORTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record_kind  (record_kind),
    .from_port    (from_port),
    .to_port      (to_port),
    .packet_total (packet_total),
    .byte_total   (byte_total),
    .last         (last)
  );

endmodule

// ----- rtl/core/pptc_front.sv -----
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on pptc_pkg.
module pptc_front #(
  parameter int PORTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pptc_pkg::MASK_W-1:0] active_ports,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        action,
  input  logic [pptc_pkg::PORT_W-1:0] source_port,
  input  logic [pptc_pkg::MASK_W-1:0] destination_mask,
  input  logic [pptc_pkg::LEN_W-1:0]  packet_length,
  output logic                        q_valid,
  output pptc_pkg::cmd_t              q_cmd,
  input  logic                        q_pop
);
  import pptc_pkg::*;

  cmd_t              cmd_in;
  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              src_ok;
  logic [MASK_W-1:0] dests;
  logic [N_W-1:0]    n;
  logic [INC_W-1:0]  len_x;
  logic [INC_W-1:0]  n_x;

  assign src_ok = (32'(source_port) < PORTS);

  always_comb begin
    dests = '0;
    n     = '0;
    for (int d = 0; d < PORTS; d++) begin
      if (src_ok && destination_mask[d] && active_ports[d] &&
          (PORT_W'(d) != source_port)) begin
        dests[d] = 1'b1;
        n        = n + N_W'(1);
      end
    end
  end

  assign len_x = INC_W'(packet_length);
  assign n_x   = INC_W'(n);

  always_comb begin
    cmd_in.dump     = (action == ACTION_DUMP);
    cmd_in.src_ok   = src_ok;
    cmd_in.src      = source_port;
    cmd_in.dests    = dests;
    cmd_in.n        = n;
    cmd_in.len      = packet_length;
    cmd_in.byte_inc = len_x * n_x;
  end

  assign item_ready = (count != QCNT_W'(QDEPTH));
  assign push       = item_valid && item_ready;
  assign q_valid    = (count != '0);
  assign q_cmd      = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

endmodule

// ----- rtl/core/pptc_back.sv -----
// Back end: counter matrix held as one wide row per source, totals and dump walk.
// Depends on pptc_pkg; takes commands from pptc_front.
module pptc_back #(
  parameter int PORTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  pptc_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        record_valid,
  input  logic                        record_ready,
  output logic [pptc_pkg::KIND_W-1:0] record_kind,
  output logic [pptc_pkg::PORT_W-1:0] from_port,
  output logic [pptc_pkg::PORT_W-1:0] to_port,
  output logic [pptc_pkg::PKT_W-1:0]  packet_total,
  output logic [pptc_pkg::BYTE_W-1:0] byte_total,
  output logic                        last
);
  import pptc_pkg::*;

  localparam int LANE_W    = PKT_W + BYTE_W;
  localparam int ROW_W     = PORTS * LANE_W;
  localparam int ROW_IDX_W = $clog2(PORTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_WR,
    S_DMP_RD,
    S_DMP_EMIT,
    S_DMP_TOT
  } state_t;

  function automatic logic [PKT_W-1:0] sat_pkt(logic [PKT_W-1:0] a, logic [PKT_W-1:0] b);
    logic [PKT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PKT_W] ? '1 : s[PKT_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] sat_byte(logic [BYTE_W-1:0] a,
                                                 logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W] ? '1 : s[BYTE_W-1:0];
  endfunction

  state_t                 state;
  logic [ROW_W-1:0]       mem [PORTS];
  logic [ROW_W-1:0]       rd_data;
  logic                   rd_ok;
  logic [ROW_W-1:0]       row_eff;
  logic [ROW_W-1:0]       row_next;
  logic [PORTS-1:0]       row_valid;
  logic [PKT_W-1:0]       all_packets;
  logic [BYTE_W-1:0]      all_bytes;
  logic [ROW_IDX_W-1:0]   s_idx;
  logic [ROW_IDX_W-1:0]   d_idx;
  logic [ROW_IDX_W-1:0]   cmd_row;
  logic [ROW_IDX_W-1:0]   rd_row;
  logic                   mem_re;
  logic                   mem_we;
  logic                   slot_free;
  logic                   d_last;
  logic                   rec_load;

  assign slot_free = !record_valid || record_ready;
  assign cmd_row   = q_cmd.src[ROW_IDX_W-1:0];
  assign row_eff   = rd_ok ? rd_data : '0;
  assign d_last    = (d_idx == ROW_IDX_W'(PORTS - 1));
  assign q_pop     = ((state == S_CNT_WR) || (state == S_DMP_TOT)) && slot_free;
  assign mem_we    = (state == S_CNT_WR) && slot_free && q_cmd.src_ok;
  assign rec_load  = slot_free && ((state == S_CNT_WR) || (state == S_DMP_TOT) ||
                                   ((state == S_DMP_EMIT) && (d_idx != s_idx)));

  always_comb begin
    row_next = row_eff;
    for (int d = 0; d < PORTS; d++) begin
      if (q_cmd.dests[d]) begin
        row_next[d*LANE_W +: PKT_W] =
          sat_pkt(row_eff[d*LANE_W +: PKT_W], PKT_W'(1));
        row_next[d*LANE_W+PKT_W +: BYTE_W] =
          sat_byte(row_eff[d*LANE_W+PKT_W +: BYTE_W], BYTE_W'(q_cmd.len));
      end
    end
  end

  always_comb begin
    mem_re = 1'b0;
    rd_row = s_idx;
    if (state == S_IDLE && q_valid && !q_cmd.dump && q_cmd.src_ok) begin
      mem_re = 1'b1;
      rd_row = cmd_row;
    end else if (state == S_DMP_RD) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_row] <= row_next;
    end
    if (mem_re) begin
      rd_data <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      record_valid <= 1'b0;
      row_valid    <= '0;
      all_packets  <= '0;
      all_bytes    <= '0;
      s_idx        <= '0;
      d_idx        <= '0;
      rd_ok        <= 1'b0;
    end else begin
      if (record_valid && record_ready && !rec_load) begin
        record_valid <= 1'b0;
      end
      if (mem_re) begin
        rd_ok <= row_valid[rd_row];
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.dump) begin
              s_idx <= '0;
              state <= S_DMP_RD;
            end else begin
              state <= S_CNT_WR;
            end
          end
        end
        S_CNT_WR: begin
          if (slot_free) begin
            if (q_cmd.src_ok) begin
              row_valid[cmd_row] <= 1'b1;
            end
            all_packets  <= sat_pkt(all_packets, PKT_W'(q_cmd.n));
            all_bytes    <= sat_byte(all_bytes, BYTE_W'(q_cmd.byte_inc));
            record_valid <= 1'b1;
            record_kind  <= KIND_ACK;
            from_port    <= '0;
            to_port      <= '0;
            packet_total <= '0;
            byte_total   <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_DMP_RD: begin
          d_idx <= '0;
          state <= S_DMP_EMIT;
        end
        S_DMP_EMIT: begin
          if ((d_idx == s_idx) || slot_free) begin
            if (d_idx != s_idx) begin
              record_valid <= 1'b1;
              record_kind  <= KIND_PAIR;
              from_port    <= PORT_W'(s_idx);
              to_port      <= PORT_W'(d_idx);
              packet_total <= row_eff[d_idx*LANE_W +: PKT_W];
              byte_total   <= row_eff[d_idx*LANE_W+PKT_W +: BYTE_W];
              last         <= 1'b0;
            end
            if (d_last) begin
              if (s_idx == ROW_IDX_W'(PORTS - 1)) begin
                state <= S_DMP_TOT;
              end else begin
                s_idx <= s_idx + ROW_IDX_W'(1);
                state <= S_DMP_RD;
              end
            end else begin
              d_idx <= d_idx + ROW_IDX_W'(1);
            end
          end
        end
        S_DMP_TOT: begin
          if (slot_free) begin
            record_valid <= 1'b1;
            record_kind  <= KIND_TOTAL;
            from_port    <= '0;
            to_port      <= '0;
            packet_total <= all_packets;
            byte_total   <= all_bytes;
            last         <= 1'b1;
            all_packets  <= '0;
            all_bytes    <= '0;
            row_valid    <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pop_only_at_end: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> ((state == S_CNT_WR) || (state == S_DMP_TOT)))
    else $error("command popped before its work finished");

  a_pair_off_diagonal: assert property (@(posedge clk) disable iff (rst)
    (state == S_DMP_EMIT && slot_free && d_idx != s_idx)
      |=> (record_kind == KIND_PAIR && from_port != to_port))
    else $error("pair record on the diagonal");

  a_dump_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DMP_TOT && slot_free)
      |=> (all_packets == '0 && all_bytes == '0 && row_valid == '0))
    else $error("counters not cleared after dump");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (record_valid && last) |-> (record_kind != KIND_PAIR))
    else $error("last set on a pair record");

endmodule
